FILE: src/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam logic [1:0] FN_PUT   = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_CLEAR = 2'd2;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_BLANK     = 8'd32;

	localparam logic [7:0] COLOR_RESET = 8'd15;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_INIT_DRAIN,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_POST
	} tcw_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic post;
	} tcw_cmd_t;

	typedef struct packed {
		logic need_sweep;
		logic sweep_last;
		logic out_free;
	} tcw_sts_t;

endpackage

`default_nettype wire

FILE: src/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                      content
// s_axis    in         s_axis_tvalid / s_axis_tready  one command word
// m_axis    out        m_axis_tvalid / m_axis_tready  one result word per command
// cfg       in         cfg_valid / cfg_ready          text colour register
//
// put without scroll, read and unknown commands go from acceptance straight to the result
// clear, and a put that scrolls, first make one pass over the simple dual-port cell
// memory, one cell per cycle, then pass through a drain state
// after reset a blanking pass over all cells runs before s_axis_tready
// rises; cfg writes are taken throughout
// a waiting result does not block the next command, only the one after it

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // char_code, cell_index, zero pad
	input  wire logic [1:0]  s_axis_tuser,  // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // cursor_col, cursor_row, cursor_offset,
	                                        // cell_data, zero pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	tcw_cmd_t    cmd;
	tcw_sts_t    sts;
	logic [6:0]  out_col;
	logic [4:0]  out_row;
	logic [10:0] out_offset;
	logic [15:0] out_cell;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (s_axis_tuser),
		.char_code  (s_axis_tdata[7:0]),
		.cell_index (s_axis_tdata[18:8]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_col    (out_col),
		.out_row    (out_row),
		.out_offset (out_offset),
		.out_cell   (out_cell)
	);

	assign m_axis_tdata = {1'b0, out_cell, out_offset, out_row, out_col};

endmodule

`default_nettype wire

FILE: src/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
	import tcw_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire tcw_sts_t sts,
	output tcw_cmd_t      cmd
);

	tcw_state_t state_q;
	tcw_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.issue  = 1'b0;
		cmd.post   = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.issue = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_INIT_DRAIN;
				end
			end
			ST_INIT_DRAIN: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.need_sweep ? ST_SWEEP : ST_POST;
				end
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_POST;
			end
			ST_POST: begin
				if (sts.out_free) begin
					cmd.post = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q != ST_IDLE)
		else $error("accepted word did not leave idle");

	a_post_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POST && sts.out_free) |=> state_q == ST_IDLE)
		else $error("result push did not return to idle");

	a_drain_then_post: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> state_q == ST_POST)
		else $error("sweep drain not followed by result");

endmodule

`default_nettype wire

FILE: src/tcw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire tcw_cmd_t    cmd,
	output tcw_sts_t         sts,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  char_code,
	input  wire logic [10:0] cell_index,
	input  wire logic        cfg_valid,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [6:0]       out_col,
	output logic [4:0]       out_row,
	output logic [10:0]      out_offset,
	output logic [15:0]      out_cell
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW  = $clog2(CELL_COUNT);
	localparam int CLW = $clog2(COLUMNS);
	localparam int RW  = $clog2(ROWS);
	localparam int XW  = ((AW > 11) ? AW : 11) + 1;
	localparam int SW  = AW + 1;

	logic [15:0]    cell_mem_q [CELL_COUNT];
	logic [15:0]    rdata_q;

	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [7:0]     text_color_q;
	logic           rd_flag_q;
	logic [AW-1:0]  sw_cnt_q;
	logic           sw_clear_q;
	logic [7:0]     sw_attr_q;
	logic           sw_v_s1;
	logic           sw_src_ok_s1;
	logic [AW-1:0]  sw_dst_s1;

	logic           out_valid_q;
	logic [6:0]     out_col_q;
	logic [4:0]     out_row_q;
	logic [10:0]    out_offset_q;
	logic [15:0]    out_cell_q;

	logic [CLW-1:0] col_d;
	logic [CLW-1:0] col_dec;
	logic [RW-1:0]  row_d;
	logic [AW-1:0]  row_base;
	logic [AW-1:0]  cur_addr;
	logic [AW-1:0]  put_addr;
	logic [7:0]     put_glyph;
	logic           put_we;
	logic           is_clear;
	logic           need_sweep;
	logic           rd_hit;
	logic [XW-1:0]  idx_x;
	logic           idx_ok;
	logic [SW-1:0]  src;
	logic           src_ok;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;
	logic [15:0]    mem_wd;
	logic           mem_re;
	logic [AW-1:0]  mem_ra;
	logic           last_col;
	logic           last_row;

	assign row_base = AW'(AW'(row_q) * AW'(COLUMNS));
	assign cur_addr = row_base + AW'(col_q);
	assign col_dec  = col_q - CLW'(1);
	assign last_col = (col_q == CLW'(COLUMNS - 1));
	assign last_row = (row_q == RW'(ROWS - 1));
	assign idx_x    = XW'(cell_index);
	assign idx_ok   = (idx_x < XW'(CELL_COUNT));

	always_comb begin
		col_d      = col_q;
		row_d      = row_q;
		put_we     = 1'b0;
		put_addr   = cur_addr;
		put_glyph  = CH_BLANK;
		need_sweep = 1'b0;
		is_clear   = 1'b0;
		rd_hit     = 1'b0;
		case (func)
			FN_PUT: begin
				case (char_code)
					CH_NEWLINE: begin
						col_d = '0;
						if (last_row) begin
							need_sweep = 1'b1;
						end else begin
							row_d = row_q + RW'(1);
						end
					end
					CH_RETURN: begin
						col_d = '0;
					end
					CH_BACKSPACE: begin
						if (col_q != '0) begin
							col_d    = col_dec;
							put_we   = 1'b1;
							put_addr = row_base + AW'(col_dec);
						end
					end
					default: begin
						put_we    = 1'b1;
						put_glyph = char_code;
						if (last_col) begin
							col_d = '0;
							if (last_row) begin
								need_sweep = 1'b1;
							end else begin
								row_d = row_q + RW'(1);
							end
						end else begin
							col_d = col_q + CLW'(1);
						end
					end
				endcase
			end
			FN_READ: begin
				rd_hit = idx_ok;
			end
			FN_CLEAR: begin
				col_d      = '0;
				row_d      = '0;
				need_sweep = 1'b1;
				is_clear   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sweep source: row below for scroll, nothing for clear
	assign src    = SW'(sw_cnt_q) + SW'(COLUMNS);
	assign src_ok = !sw_clear_q && (src < SW'(CELL_COUNT));

	assign mem_we = sw_v_s1 || (cmd.accept && put_we);
	assign mem_wa = sw_v_s1 ? sw_dst_s1 : put_addr;
	assign mem_wd = sw_v_s1 ? (sw_src_ok_s1 ? rdata_q : {sw_attr_q, CH_BLANK})
	                        : {text_color_q, put_glyph};
	assign mem_re = (cmd.issue && src_ok) || (cmd.accept && rd_hit);
	assign mem_ra = cmd.issue ? AW'(src) : idx_x[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= cell_mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RESET;
		end else if (cfg_valid) begin
			text_color_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			rd_flag_q  <= 1'b0;
			sw_cnt_q   <= '0;
			sw_clear_q <= 1'b1;
			sw_attr_q  <= COLOR_RESET;
			sw_v_s1    <= 1'b0;
		end else begin
			sw_v_s1 <= cmd.issue;
			if (cmd.accept) begin
				col_q     <= col_d;
				row_q     <= row_d;
				rd_flag_q <= rd_hit;
				if (need_sweep) begin
					sw_cnt_q   <= '0;
					sw_clear_q <= is_clear;
					sw_attr_q  <= text_color_q;
				end
			end else if (cmd.issue) begin
				sw_cnt_q <= sts.sweep_last ? '0 : sw_cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sw_dst_s1    <= sw_cnt_q;
		sw_src_ok_s1 <= src_ok;
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_col_q    <= 7'(col_q);
			out_row_q    <= 5'(row_q);
			out_offset_q <= 11'(cur_addr);
			out_cell_q   <= rd_flag_q ? rdata_q : 16'd0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign out_offset = out_offset_q;
	assign out_cell   = out_cell_q;

	assign sts.need_sweep = need_sweep;
	assign sts.sweep_last = (sw_cnt_q == AW'(CELL_COUNT - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	a_cursor_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor outside grid");

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(sw_v_s1 && cmd.accept && put_we))
		else $error("sweep and put write in same cycle");

	a_sweep_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sw_cnt_q) < CELL_COUNT)
		else $error("sweep counter past grid");

endmodule

`default_nettype wire
